// ===== hw/rtl/rri_pkg.sv =====
// Shared types and constants for the ray/rectangle intersection block.
package rri_pkg;

  localparam int CW = 21;  // Q11.10 vector component width

  // Three packed components, x in the low bits
  typedef logic [2:0][CW-1:0] vec_t;

  // Configuration register indexes
  localparam logic [1:0] REG_CORNER   = 2'd0;
  localparam logic [1:0] REG_EDGE_ONE = 2'd1;
  localparam logic [1:0] REG_EDGE_TWO = 2'd2;
  localparam logic [1:0] REG_NORMAL   = 2'd3;

  typedef struct packed {
    vec_t corner;
    vec_t edge1;
    vec_t edge2;
    vec_t normal;
  } cfg_t;

  typedef struct packed {
    vec_t        origin;
    vec_t        dir;
    logic [30:0] far_limit;
  } ray_t;

  // Classified ray, front to back
  typedef struct packed {
    logic        miss;
    logic [42:0] ua;    // |(P-O).N|
    logic [41:0] ub;    // |D.N|
    logic [41:0] d2;    // D.D
    vec_t        origin;
    vec_t        dir;
    logic [30:0] far_limit;
  } fb_item_t;

  // Partial result carried through the tail of the back pipeline
  typedef struct packed {
    logic        miss;
    logic [30:0] hdist;
    vec_t        h;
  } mid_t;

  // One result item
  typedef struct packed {
    logic        hit;
    logic [30:0] hit_dist;
    vec_t        h;
    logic [15:0] u;
    logic [15:0] v;
  } res_t;

endpackage

// ===== hw/rtl/ray_rectangle_intersect.sv =====
// Top level: ray against rectangle intersection, queue-style ports.
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------
//  ray in    push / full            origin_x/y/z, dir_x/y/z, far_limit
//  result    empty / pop            hit, hit_dist, hit_x/y/z, coord_u/v
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One ray per cycle while neither queue fills; each ray passes through the
// 31-step square root, the 44-step hit point divider and the 17-step u/v
// divider in the back pipeline. The front (2 stages) and back stall on
// their own; the queue between them and the output queue absorb backpressure.
// Reset clears control state and the four registers to zero; no clearing pass.
module ray_rectangle_intersect #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic               clk,
  input  logic               rst,
  // ray input
  input  logic               push,
  output logic               full,
  input  logic signed [20:0] origin_x,
  input  logic signed [20:0] origin_y,
  input  logic signed [20:0] origin_z,
  input  logic signed [20:0] dir_x,
  input  logic signed [20:0] dir_y,
  input  logic signed [20:0] dir_z,
  input  logic [30:0]        far_limit,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic [30:0]        hit_dist,
  output logic signed [20:0] hit_x,
  output logic signed [20:0] hit_y,
  output logic signed [20:0] hit_z,
  output logic [15:0]        coord_u,
  output logic [15:0]        coord_v,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [62:0]        cfg_data
);
  import rri_pkg::*;

  cfg_t     cfg;
  ray_t     ray;
  fb_item_t f_qdata;
  fb_item_t b_qdata;
  res_t     b_odata;
  res_t     res;
  logic     f_qpush, mid_full, mid_empty, b_qpop;
  logic     b_opush, out_full;
  logic [$bits(fb_item_t)-1:0] mid_rdata;
  logic [$bits(res_t)-1:0]     out_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CORNER:   cfg.corner <= cfg_data;
        REG_EDGE_ONE: cfg.edge1  <= cfg_data;
        REG_EDGE_TWO: cfg.edge2  <= cfg_data;
        REG_NORMAL:   cfg.normal <= cfg_data;
      endcase
    end
  end

  assign ray.origin    = {origin_z, origin_y, origin_x};
  assign ray.dir       = {dir_z, dir_y, dir_x};
  assign ray.far_limit = far_limit;

  rri_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .ray    (ray),
    .cfg    (cfg),
    .q_push (f_qpush),
    .q_data (f_qdata),
    .q_full (mid_full)
  );

  rri_fifo #(.WIDTH($bits(fb_item_t)), .DEPTH(QUEUE_DEPTH)) u_midq (
    .clk   (clk),
    .rst   (rst),
    .push  (f_qpush),
    .wdata (f_qdata),
    .full  (mid_full),
    .pop   (b_qpop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign b_qdata = fb_item_t'(mid_rdata);

  rri_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (mid_empty),
    .q_data  (b_qdata),
    .q_pop   (b_qpop),
    .o_full  (out_full),
    .o_push  (b_opush),
    .o_data  (b_odata)
  );

  rri_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (b_opush),
    .wdata (b_odata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign res      = res_t'(out_rdata);
  assign hit      = res.hit;
  assign hit_dist = res.hit_dist;
  assign hit_x    = $signed(res.h[0]);
  assign hit_y    = $signed(res.h[1]);
  assign hit_z    = $signed(res.h[2]);
  assign coord_u  = res.u;
  assign coord_v  = res.v;

`ifndef NO_ASSERTIONS
  // front never pushes into a full queue
  a_mid_push: assert property (@(posedge clk) disable iff (rst)
    f_qpush |-> !mid_full)
    else $error("front transfer into full queue");

  // back never pops an empty queue
  a_mid_pop: assert property (@(posedge clk) disable iff (rst)
    b_qpop |-> !mid_empty)
    else $error("back pop from empty queue");

  // back never pushes into a full output queue
  a_out_push: assert property (@(posedge clk) disable iff (rst)
    b_opush |-> !out_full)
    else $error("result transfer into full output queue");

  // a miss carries zero distance and zero u/v coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hit) |-> (hit_dist == '0 && coord_u == '0 && coord_v == '0))
    else $error("miss with nonzero result fields");
`endif

endmodule

// ===== hw/rtl/rri_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
module rri_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // only transfers that the queue can take
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rri_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rri_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);
  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem [QW];
  logic [DW-1:0] dvs [QW];
  logic [QW-1:0] qb  [QW+1];
  logic          ov  [QW+1];

  // input stage: overflow when quotient needs more than QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(num);
      dvs[0] <= den;
      qb[0]  <= '0;
      ov[0]  <= ((W+1)'(num) >= ((W+1)'(den) << QW));
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [W-1:0] trial;
    logic         take;
    assign trial = W'(dvs[j]) << (QW - 1 - j);
    assign take  = (rem[j] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        qb[j+1] <= take ? (qb[j] | (QW'(1) << (QW - 1 - j))) : qb[j];
        ov[j+1] <= ov[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= take ? rem[j] - trial : rem[j];
          dvs[j+1] <= dvs[j];
        end
      end
    end
  end

  assign quo = qb[QW];
  assign ovf = ov[QW];

endmodule

// ===== hw/rtl/rri_front.sv =====
// Front end: dot products against the plane and ray classification.
module rri_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rri_pkg::ray_t     ray,
  input  rri_pkg::cfg_t     cfg,
  output logic              q_push,
  output rri_pkg::fb_item_t q_data,
  input  logic              q_full
);
  import rri_pkg::*;

  logic fe;
  logic st1_v;
  logic st2_v;

  logic signed [21:0] diff     [3];
  logic signed [42:0] pa_next  [3];
  logic signed [41:0] pb_next  [3];
  logic signed [41:0] pd_next  [3];

  logic signed [42:0] pa [3];
  logic signed [41:0] pb [3];
  logic [40:0]        pd [3];
  ray_t               ray1;

  logic signed [44:0] a;
  logic signed [43:0] b;
  logic [41:0]        d2;
  ray_t               ray2;

  // stall when the last stage holds an item the queue cannot take
  assign fe     = !(st2_v && q_full);
  assign full   = !fe;
  assign q_push = st2_v && !q_full;

  // per-component products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = $signed({cfg.corner[i][CW-1], cfg.corner[i]}) -
                   $signed({ray.origin[i][CW-1], ray.origin[i]});
      pa_next[i] = 43'(diff[i]) * 43'($signed(cfg.normal[i]));
      pb_next[i] = 42'($signed(ray.dir[i])) * 42'($signed(cfg.normal[i]));
      pd_next[i] = 42'($signed(ray.dir[i])) * 42'($signed(ray.dir[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= pa_next[i];
        pb[i] <= pb_next[i];
        pd[i] <= pd_next[i][40:0];
      end
      ray1 <= ray;
      a    <= 45'(pa[0]) + 45'(pa[1]) + 45'(pa[2]);
      b    <= 44'(pb[0]) + 44'(pb[1]) + 44'(pb[2]);
      d2   <= 42'(pd[0]) + 42'(pd[1]) + 42'(pd[2]);
      ray2 <= ray1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_v <= 1'b0;
      st2_v <= 1'b0;
    end else if (fe) begin
      st1_v <= push;
      st2_v <= st1_v;
    end
  end

  // parallel ray, origin on plane, or plane behind the ray: miss
  always_comb begin
    q_data.miss      = (b == '0) || (a == '0) || (a[44] != b[43]);
    q_data.ua        = a[44] ? 43'(-a) : a[42:0];
    q_data.ub        = b[43] ? 42'(-b) : b[41:0];
    q_data.d2        = d2;
    q_data.origin    = ray2.origin;
    q_data.dir       = ray2.dir;
    q_data.far_limit = ray2.far_limit;
  end

endmodule

// ===== hw/rtl/rri_back.sv =====
// Back end: length, distance, hit point, edge projections and u/v.
module rri_back (
  input  logic              clk,
  input  logic              rst,
  input  rri_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  rri_pkg::fb_item_t q_data,
  output logic              q_pop,
  input  logic              o_full,
  output logic              o_push,
  output rri_pkg::res_t     o_data
);
  import rri_pkg::*;

  localparam int SQ_STEPS = 31;
  localparam int QD_LAT   = 44;   // hit point divider latency
  localparam int TD_PAD   = 11;   // distance divider is shorter by this
  localparam int UV_LAT   = 17;

  localparam logic [43:0]        QSAT = 44'(1) << 43;
  localparam logic signed [45:0] HMIN = -46'sd1048576;
  localparam logic signed [45:0] HMAX = 46'sd1048575;
  localparam logic signed [46:0] DLIM = 47'sd2199023255552;

  logic be;

  // ---- edge lengths squared, from configuration
  vec_t               edges [2];
  logic signed [41:0] sqf   [2][3];
  logic [40:0]        sq    [2][3];
  logic [41:0]        slen  [2];

  assign edges[0] = cfg.edge1;
  assign edges[1] = cfg.edge2;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        sqf[e][i] = 42'($signed(edges[e][i])) * 42'($signed(edges[e][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        sq[e][i] <= sqf[e][i][40:0];
      end
      slen[e] <= 42'(sq[e][0]) + 42'(sq[e][1]) + 42'(sq[e][2]);
    end
  end

  // ---- square root of D.D * 2^20, one result bit per stage
  logic     s_v [SQ_STEPS+1];
  fb_item_t s_p [SQ_STEPS+1];
  logic [62:0] s_x [SQ_STEPS+1];
  logic [62:0] s_r [SQ_STEPS+1];

  logic e_v_last;
  assign be     = !(e_v_last && o_full);
  assign q_pop  = be && !q_empty;
  assign o_push = e_v_last && !o_full;

  assign s_v[0] = !q_empty;
  assign s_p[0] = q_data;
  assign s_x[0] = {1'b0, q_data.d2, 20'b0};
  assign s_r[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [62:0] BITV = 63'(1) << (60 - 2 * j);
    logic [62:0] trial;
    assign trial = s_r[j] + BITV;

    always_ff @(posedge clk) begin
      if (be) begin
        s_p[j+1] <= s_p[j];
        if (s_x[j] >= trial) begin
          s_x[j+1] <= s_x[j] - trial;
          s_r[j+1] <= (s_r[j] >> 1) + BITV;
        end else begin
          s_x[j+1] <= s_x[j];
          s_r[j+1] <= s_r[j] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[j+1] <= 1'b0;
      end else if (be) begin
        s_v[j+1] <= s_v[j];
      end
    end
  end

  // ---- numerators: |A|*len and |A|*|D_i|, split into partial products
  logic [30:0]  lf;
  logic [20:0]  dmag [3];
  logic         m1_v;
  fb_item_t     m1_p;
  logic [52:0]  m1_tl;
  logic [51:0]  m1_th;
  logic [42:0]  m1_ql [3];
  logic [41:0]  m1_qh [3];
  logic         m2_v;
  fb_item_t     m2_p;
  logic [73:0]  m2_tnum;
  logic [63:0]  m2_qnum [3];

  assign lf = s_r[SQ_STEPS][30:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = s_p[SQ_STEPS].dir[i][CW-1] ? 21'(-s_p[SQ_STEPS].dir[i])
                                           : s_p[SQ_STEPS].dir[i];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      m1_p  <= s_p[SQ_STEPS];
      m1_tl <= 53'(s_p[SQ_STEPS].ua[21:0]) * 53'(lf);
      m1_th <= 52'(s_p[SQ_STEPS].ua[42:22]) * 52'(lf);
      for (int i = 0; i < 3; i++) begin
        m1_ql[i] <= 43'(s_p[SQ_STEPS].ua[21:0]) * 43'(dmag[i]);
        m1_qh[i] <= 42'(s_p[SQ_STEPS].ua[42:22]) * 42'(dmag[i]);
      end
      m2_p    <= m1_p;
      m2_tnum <= {m1_th, 22'b0} + 74'(m1_tl);
      for (int i = 0; i < 3; i++) begin
        m2_qnum[i] <= {m1_qh[i], 22'b0} + 64'(m1_ql[i]);
      end
    end
  end

  // ---- dividers: distance and the three hit point offsets
  logic [31:0] t_quo;
  logic        t_ovf;
  logic [42:0] q_quo [3];
  logic        q_ovf [3];

  rri_div #(.NW(74), .DW(52), .QW(32)) u_tdiv (
    .clk (clk),
    .en  (be),
    .num (m2_tnum),
    .den ({m2_p.ub, 10'b0}),
    .quo (t_quo),
    .ovf (t_ovf)
  );

  for (genvar i = 0; i < 3; i++) begin : g_qdiv
    rri_div #(.NW(64), .DW(42), .QW(43)) u_qdiv (
      .clk (clk),
      .en  (be),
      .num (m2_qnum[i]),
      .den (m2_p.ub),
      .quo (q_quo[i]),
      .ovf (q_ovf[i])
    );
  end

  // align the distance with the longer dividers
  logic [31:0] td_q [TD_PAD+1];
  logic        td_o [TD_PAD+1];
  assign td_q[0] = t_quo;
  assign td_o[0] = t_ovf;

  for (genvar j = 0; j < TD_PAD; j++) begin : g_tpad
    always_ff @(posedge clk) begin
      if (be) begin
        td_q[j+1] <= td_q[j];
        td_o[j+1] <= td_o[j];
      end
    end
  end

  // payload alongside the dividers
  logic     d_v [QD_LAT+1];
  fb_item_t d_p [QD_LAT+1];
  assign d_v[0] = m2_v;
  assign d_p[0] = m2_p;

  for (genvar j = 0; j < QD_LAT; j++) begin : g_dpay
    always_ff @(posedge clk) begin
      if (be) begin
        d_p[j+1] <= d_p[j];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[j+1] <= 1'b0;
      end else if (be) begin
        d_v[j+1] <= d_v[j];
      end
    end
  end

  // ---- far test, hit point, clamped offset from the corner
  logic [43:0]        qs  [3];
  logic signed [45:0] ox  [3];
  logic signed [45:0] h   [3];
  logic signed [46:0] dif [3];
  logic [20:0]        hs  [3];
  logic [42:0]        dd  [3];
  logic               t_ok;
  mid_t               c1_next;

  always_comb begin
    t_ok = !td_o[TD_PAD] && (td_q[TD_PAD] < {1'b0, d_p[QD_LAT].far_limit});
    for (int i = 0; i < 3; i++) begin
      qs[i]  = q_ovf[i] ? QSAT : {1'b0, q_quo[i]};
      ox[i]  = 46'($signed(d_p[QD_LAT].origin[i]));
      h[i]   = d_p[QD_LAT].dir[i][CW-1] ? ox[i] - $signed({2'b0, qs[i]})
                                        : ox[i] + $signed({2'b0, qs[i]});
      dif[i] = 47'(h[i]) - 47'($signed(cfg.corner[i]));
      if (h[i] < HMIN) begin
        hs[i] = HMIN[20:0];
      end else if (h[i] > HMAX) begin
        hs[i] = HMAX[20:0];
      end else begin
        hs[i] = h[i][20:0];
      end
      if (dif[i] > DLIM) begin
        dd[i] = DLIM[42:0];
      end else if (dif[i] < -DLIM) begin
        dd[i] = 43'(-DLIM);
      end else begin
        dd[i] = dif[i][42:0];
      end
    end
    c1_next.miss  = d_p[QD_LAT].miss || !t_ok;
    c1_next.hdist = td_q[TD_PAD][30:0];
    c1_next.h     = {hs[2], hs[1], hs[0]};
  end

  logic               c1_v, c2_v, c3_v, c4_v;
  mid_t               c1_m, c2_m, c3_m, c4_m;
  logic [42:0]        c1_dd [3];
  logic signed [43:0] c2_pl [2][3];
  logic signed [41:0] c2_ph [2][3];
  logic signed [63:0] c3_pr [2][3];
  logic signed [63:0] c4_k  [2];

  always_ff @(posedge clk) begin
    if (be) begin
      c1_m  <= c1_next;
      c1_dd <= dd;
      // projections onto the edges, split partial products
      c2_m  <= c1_m;
      for (int e = 0; e < 2; e++) begin
        for (int i = 0; i < 3; i++) begin
          c2_pl[e][i] <= 44'($signed({1'b0, c1_dd[i][21:0]})) *
                         44'($signed(edges[e][i]));
          c2_ph[e][i] <= 42'($signed(c1_dd[i][42:22])) * 42'($signed(edges[e][i]));
        end
      end
      c3_m <= c2_m;
      for (int e = 0; e < 2; e++) begin
        for (int i = 0; i < 3; i++) begin
          c3_pr[e][i] <= (64'(c2_ph[e][i]) <<< 22) + 64'(c2_pl[e][i]);
        end
      end
      c4_m <= c3_m;
      for (int e = 0; e < 2; e++) begin
        c4_k[e] <= c3_pr[e][0] + c3_pr[e][1] + c3_pr[e][2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
      c4_v <= 1'b0;
    end else if (be) begin
      c1_v <= d_v[QD_LAT];
      c2_v <= c1_v;
      c3_v <= c2_v;
      c4_v <= c3_v;
    end
  end

  // ---- projection range test and u/v division
  logic kbad [2];
  mid_t e_m [UV_LAT+1];
  logic e_v [UV_LAT+1];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      kbad[e] = c4_k[e][63] || (c4_k[e] > $signed({22'b0, slen[e]}));
    end
    e_m[0]      = c4_m;
    e_m[0].miss = c4_m.miss || kbad[0] || kbad[1];
  end
  assign e_v[0] = c4_v;

  logic [15:0] uv_quo [2];
  logic        uv_ovf [2];

  for (genvar e = 0; e < 2; e++) begin : g_uvdiv
    rri_div #(.NW(57), .DW(42), .QW(16)) u_uvdiv (
      .clk (clk),
      .en  (be),
      .num ({c4_k[e][41:0], 15'b0}),
      .den (slen[e]),
      .quo (uv_quo[e]),
      .ovf (uv_ovf[e])
    );
  end

  for (genvar j = 0; j < UV_LAT; j++) begin : g_epay
    always_ff @(posedge clk) begin
      if (be) begin
        e_m[j+1] <= e_m[j];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        e_v[j+1] <= 1'b0;
      end else if (be) begin
        e_v[j+1] <= e_v[j];
      end
    end
  end

  assign e_v_last = e_v[UV_LAT];

  // valid at the head of the back pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (be) begin
      m1_v <= s_v[SQ_STEPS];
      m2_v <= m1_v;
    end
  end

  // result: zero edge gives a zero coordinate (flagged as overflow)
  always_comb begin
    if (e_m[UV_LAT].miss) begin
      o_data = '0;
    end else begin
      o_data.hit      = 1'b1;
      o_data.hit_dist = e_m[UV_LAT].hdist;
      o_data.h        = e_m[UV_LAT].h;
      o_data.u        = uv_ovf[0] ? '0 : uv_quo[0];
      o_data.v        = uv_ovf[1] ? '0 : uv_quo[1];
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ray/rectangle intersection block.
module tb;
  import rri_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               hit;
    logic [30:0]        hdist;
    logic signed [20:0] hx;
    logic signed [20:0] hy;
    logic signed [20:0] hz;
    logic [15:0]        u;
    logic [15:0]        v;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [20:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [20:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic [30:0] far_limit = '0;
  logic empty;
  logic pop = 1'b0;
  logic hit;
  logic [30:0] hit_dist;
  logic signed [20:0] hit_x, hit_y, hit_z;
  logic [15:0] coord_u, coord_v;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [62:0] cfg_data = '0;

  logic [62:0] geom_regs [4];
  isect_t expected_hits[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  ray_rectangle_intersect u_dut (.*);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic signed [63:0] comp(input logic [62:0] r, input int i);
    logic [20:0] f;
    f = r[21*i +: 21];
    return {{43{f[20]}}, f};
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b, xx;
    r = 0;
    xx = x;
    b = 64'd1 << 62;
    while (b > xx) b = b >> 2;
    while (b != 0) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clip(input logic signed [63:0] x,
                                              input logic signed [63:0] lo,
                                              input logic signed [63:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Expected intersection of one ray against the current geometry
  function automatic isect_t intersect_ray(input logic [20:0] o_in[3],
                                           input logic [20:0] d_in[3],
                                           input logic [30:0] lim);
    logic signed [63:0] o[3], d[3], p[3], e1[3], e2[3], n[3], h[3], dd[3];
    logic signed [63:0] a, b, k1, k2, s1, s2, q;
    logic [63:0] d2, ua, ub, lf, t, cu, cv;
    logic [127:0] tw;
    isect_t r;
    r = '0;
    a = 0; b = 0; d2 = 0; k1 = 0; k2 = 0; s1 = 0; s2 = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = {{43{o_in[i][20]}}, o_in[i]};
      d[i] = {{43{d_in[i][20]}}, d_in[i]};
      p[i] = comp(geom_regs[REG_CORNER], i);
      e1[i] = comp(geom_regs[REG_EDGE_ONE], i);
      e2[i] = comp(geom_regs[REG_EDGE_TWO], i);
      n[i] = comp(geom_regs[REG_NORMAL], i);
      a += (p[i] - o[i]) * n[i];
      b += d[i] * n[i];
      d2 += d[i] * d[i];
    end
    if (b == 0 || a == 0 || ((a < 0) != (b < 0))) return r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    lf = int_sqrt(d2 << 20);
    tw = (128'(ua) * 128'(lf)) / 128'(ub << 10);
    t = tw[63:0];
    if (t >= 64'(lim)) return r;
    for (int i = 0; i < 3; i++) begin
      q = ((ua * (d[i] < 0 ? -d[i] : d[i])) / ub);
      h[i] = o[i] + ((d[i] < 0) ? -q : q);
      dd[i] = clip(h[i] - p[i], -(64'sd1 << 41), 64'sd1 << 41);
    end
    for (int i = 0; i < 3; i++) begin
      k1 += dd[i] * e1[i]; s1 += e1[i] * e1[i];
      k2 += dd[i] * e2[i]; s2 += e2[i] * e2[i];
    end
    if (k1 < 0 || k1 > s1 || k2 < 0 || k2 > s2) return r;
    cu = s1 != 0 ? (64'(k1) << 15) / 64'(s1) : 0;
    cv = s2 != 0 ? (64'(k2) << 15) / 64'(s2) : 0;
    r.hit = 1'b1;
    r.hdist = t > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : t[30:0];
    r.hx = 21'(clip(h[0], -1048576, 1048575));
    r.hy = 21'(clip(h[1], -1048576, 1048575));
    r.hz = 21'(clip(h[2], -1048576, 1048575));
    r.u = cu[15:0];
    r.v = cv[15:0];
    return r;
  endfunction

  // Result side: random pop, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    isect_t exp_r;
    if (!rst && pop && !empty) begin
      if (expected_hits.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        exp_r = expected_hits.pop_front();
        if (hit !== exp_r.hit) begin
          $error("hit exp %0d got %0d", exp_r.hit, hit); error_count++;
        end
        if (hit_dist !== exp_r.hdist) begin
          $error("hit_dist exp %0d got %0d", exp_r.hdist, hit_dist); error_count++;
        end
        if (hit_x !== exp_r.hx) begin
          $error("hit_x exp %0d got %0d", exp_r.hx, hit_x); error_count++;
        end
        if (hit_y !== exp_r.hy) begin
          $error("hit_y exp %0d got %0d", exp_r.hy, hit_y); error_count++;
        end
        if (hit_z !== exp_r.hz) begin
          $error("hit_z exp %0d got %0d", exp_r.hz, hit_z); error_count++;
        end
        if (coord_u !== exp_r.u) begin
          $error("coord_u exp %0d got %0d", exp_r.u, coord_u); error_count++;
        end
        if (coord_v !== exp_r.v) begin
          $error("coord_v exp %0d got %0d", exp_r.v, coord_v); error_count++;
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [62:0] pack3(input int x, input int y, input int z);
    return {21'(z), 21'(y), 21'(x)};
  endfunction

  // Stop sending and wait for every outstanding result
  task automatic drain();
    push <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [62:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    geom_regs[idx] = val;
  endtask

  task automatic set_geometry(input logic [62:0] pc, input logic [62:0] a,
                              input logic [62:0] b, input logic [62:0] nv);
    drain();
    repeat (120) @(posedge clk);
    write_reg(REG_CORNER, pc);
    write_reg(REG_EDGE_ONE, a);
    write_reg(REG_EDGE_TWO, b);
    write_reg(REG_NORMAL, nv);
    cfg_valid <= 1'b0;
  endtask

  // One ray transfer, with optional idle cycles before it
  task automatic send_ray(input int ox, input int oy, input int oz, input int dx,
                          input int dy, input int dz, input logic [30:0] lim);
    logic [20:0] ov[3], dv[3];
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    ov[0] = 21'(ox); ov[1] = 21'(oy); ov[2] = 21'(oz);
    dv[0] = 21'(dx); dv[1] = 21'(dy); dv[2] = 21'(dz);
    push <= 1'b1;
    origin_x <= ov[0]; origin_y <= ov[1]; origin_z <= ov[2];
    dir_x <= dv[0]; dir_y <= dv[1]; dir_z <= dv[2];
    far_limit <= lim;
    do @(posedge clk); while (full);
    expected_hits.push_back(intersect_ray(ov, dv, lim));
  endtask

  function automatic int rnd21();
    return int'($urandom_range(2097151)) - 1048576;
  endfunction

  function automatic int near(input int c, input int span);
    return c + int'($urandom_range(2 * span)) - span;
  endfunction

  // Edge cases on an axis-aligned unit-ish square in the z=0 plane
  task automatic test_directed();
    set_geometry(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(0, 4096, 0),
                 pack3(0, 0, 1024));
    send_ray(1024, 1024, 4096, 0, 0, -1024, 31'h7FFF_FFFF);  // hit inside the square
    send_ray(1024, 1024, 4096, 0, 0, 1024, 31'h7FFF_FFFF);   // pointing away
    send_ray(1024, 1024, 4096, 1024, 0, 0, 31'h7FFF_FFFF);   // parallel
    send_ray(1024, 1024, 4096, 0, 0, 0, 31'h7FFF_FFFF);      // zero dir
    send_ray(1024, 1024, 0, 0, 0, -1024, 31'h7FFF_FFFF);     // origin on plane
    send_ray(1024, 1024, 4096, 0, 0, -1024, 4096);           // t equals far
    send_ray(1024, 1024, 4096, 0, 0, -1024, 4097);           // just inside far
    send_ray(1024, 1024, 4096, 0, 0, -1024, 0);              // zero far
    send_ray(0, 0, 4096, 0, 0, -1024, 31'h7FFF_FFFF);        // corner u=v=0
    send_ray(4096, 4096, 4096, 0, 0, -1024, 31'h7FFF_FFFF);  // u=v=1
    send_ray(4097, 0, 4096, 0, 0, -1024, 31'h7FFF_FFFF);     // outside edge
    send_ray(-1, 0, 4096, 0, 0, -1024, 31'h7FFF_FFFF);       // outside below
    send_ray(-1048576, -1048576, 1048575, 1048575, 1048575, -1, 31'h7FFF_FFFF);
    send_ray(1048575, 1048575, -1048576, -1048576, -1048576, 1048575,
             31'h7FFF_FFFF);
    send_ray(1024, 1024, 1, 0, 0, -1048576, 31'h7FFF_FFFF);  // tiny t
    // Extreme register values, degenerate edges, overflow of hit point
    set_geometry(pack3(-1048576, -1048576, 1048575), pack3(1048575, -1048576, 0),
                 pack3(0, 0, 0), pack3(1048575, 1048575, -1048576));
    for (int i = 0; i < 4; i++)
      send_ray(rnd21(), rnd21(), rnd21(), rnd21(), rnd21(), rnd21(), 31'($urandom()));
    set_geometry('1, '1, '1, '1);
    for (int i = 0; i < 4; i++)
      send_ray(rnd21(), rnd21(), rnd21(), rnd21(), rnd21(), rnd21(), 31'($urandom()));
    set_geometry('0, '0, '0, '0);
    send_ray(0, 0, 0, 1, 1, 1, 31'h7FFF_FFFF);
  endtask

  // Random geometry per phase; mostly rays aimed into the rectangle
  task automatic test_random(input int n_rays);
    int cx, cy, cz, ax, ay, bx, by, nz, s, tx, ty, span;
    span = 1 << $urandom_range(16, 4);
    cx = near(0, span); cy = near(0, span); cz = near(0, span);
    ax = near(0, span); ay = near(0, span / 4);
    bx = near(0, span / 4); by = near(0, span);
    nz = int'($urandom_range(2048, 1)) * ($urandom_range(1) ? 1 : -1);
    set_geometry(pack3(cx, cy, cz), pack3(ax, ay, 0), pack3(bx, by, 0),
                 pack3(near(0, 64), near(0, 64), nz));
    for (int i = 0; i < n_rays; i++) begin
      s = $urandom_range(99);
      if (s < 75) begin
        tx = cx + (ax * int'($urandom_range(1100))) / 1000
                + (bx * int'($urandom_range(1100))) / 1000;
        ty = cy + (ay * int'($urandom_range(1100))) / 1000
                + (by * int'($urandom_range(1100))) / 1000;
        send_ray(near(tx, 2048), near(ty, 2048), cz + near(0, 1 << 14),
                 near(0, 512), near(0, 512), near(0, 4096),
                 $urandom_range(1) ? 31'h7FFF_FFFF : 31'($urandom_range(1 << 20)));
      end else begin
        send_ray(rnd21(), rnd21(), rnd21(), rnd21(), rnd21(), rnd21(),
                 31'($urandom()));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) geom_regs[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 24; recv_idle_pct = 84;
    test_directed();
    for (int i = 0; i < 5; i++) test_random(45);
    // Sender holds off until the result queue is empty
    drain();
    send_idle_pct = 84; recv_idle_pct = 24;
    for (int i = 0; i < 5; i++) test_random(45);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 4; i++) test_random(45);
    drain();
    repeat (150) @(posedge clk);
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/rri_pkg.sv
hw/rtl/rri_fifo.sv
hw/rtl/rri_div.sv
hw/rtl/rri_front.sv
hw/rtl/rri_back.sv
hw/rtl/ray_rectangle_intersect.sv
tb/sv/tb.sv
